### rtl/tscd_pkg.sv
`default_nettype none

package tscd_pkg;

  // Sample format and gain formats.
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int GAIN_BITS   = 16;
  localparam int GAIN_FRAC   = 13;
  localparam int DRIVE_FRAC  = 10;

  // Gained input is clamped just below 4.0, the tanh argument at exactly 8.0.
  localparam int G_BITS = SAMPLE_BITS + 1;
  localparam int U_BITS = FRAC_BITS + 4;
  localparam int Y_BITS = G_BITS;

  // Tanh table geometry.
  localparam int TANH_DEPTH   = 1024;
  localparam int TAB_ABITS    = $clog2(TANH_DEPTH);
  localparam int TAB_ENTRIES  = TANH_DEPTH + 1;
  localparam int IDX_BITS     = TAB_ABITS + 1;
  localparam int FRAC_LO_BITS = FRAC_BITS + 3 - TAB_ABITS;
  localparam int T_BITS       = SAMPLE_BITS;

  // Table build arithmetic: e = exp(-16*i/depth) in Q30.
  localparam int EXP_FRAC     = 30;
  localparam int EXP_BITS     = EXP_FRAC + 1;
  localparam int DEN_BITS     = EXP_FRAC + 2;
  localparam int QUO_BITS     = T_BITS;
  localparam int NUM_BITS     = QUO_BITS + DEN_BITS - 1;
  localparam int DIV_CNT_BITS = $clog2(QUO_BITS);

  // Shared multiplier operand widths.
  localparam int MUL_A_BITS = (G_BITS > EXP_BITS) ? G_BITS : EXP_BITS;
  localparam int MUL_B_BITS = (T_BITS > EXP_FRAC) ? T_BITS : EXP_FRAC;
  localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

  // Step factor exp(-16/depth) as a Taylor series through the tenth power, in Q30.
  localparam longint unsigned EXP_ONE  = 64'd1 << EXP_FRAC;
  localparam longint unsigned EXP_STEP = (64'd16 << EXP_FRAC) / TANH_DEPTH;
  localparam longint unsigned EXP_T1   = ((EXP_ONE * EXP_STEP) >> EXP_FRAC) / 1;
  localparam longint unsigned EXP_T2   = ((EXP_T1 * EXP_STEP) >> EXP_FRAC) / 2;
  localparam longint unsigned EXP_T3   = ((EXP_T2 * EXP_STEP) >> EXP_FRAC) / 3;
  localparam longint unsigned EXP_T4   = ((EXP_T3 * EXP_STEP) >> EXP_FRAC) / 4;
  localparam longint unsigned EXP_T5   = ((EXP_T4 * EXP_STEP) >> EXP_FRAC) / 5;
  localparam longint unsigned EXP_T6   = ((EXP_T5 * EXP_STEP) >> EXP_FRAC) / 6;
  localparam longint unsigned EXP_T7   = ((EXP_T6 * EXP_STEP) >> EXP_FRAC) / 7;
  localparam longint unsigned EXP_T8   = ((EXP_T7 * EXP_STEP) >> EXP_FRAC) / 8;
  localparam longint unsigned EXP_T9   = ((EXP_T8 * EXP_STEP) >> EXP_FRAC) / 9;
  localparam longint unsigned EXP_T10  = ((EXP_T9 * EXP_STEP) >> EXP_FRAC) / 10;
  localparam longint unsigned EXP_EVEN =
      EXP_ONE + EXP_T2 + EXP_T4 + EXP_T6 + EXP_T8 + EXP_T10;
  localparam longint unsigned EXP_ODD  = EXP_T1 + EXP_T3 + EXP_T5 + EXP_T7 + EXP_T9;
  localparam longint unsigned EXP_RATIO = EXP_EVEN - EXP_ODD;

  localparam logic [MUL_B_BITS-1:0] EXP_RATIO_C = MUL_B_BITS'(EXP_RATIO);
  localparam logic [EXP_BITS-1:0]   EXP_ONE_C   = EXP_BITS'(EXP_ONE);

  // Saturation limits.
  localparam logic [G_BITS-1:0]      GAINED_MAX = '1;
  localparam logic [U_BITS-1:0]      ARG_MAX    = U_BITS'(1) << (FRAC_BITS + 3);
  localparam logic [SAMPLE_BITS-1:0] OUT_MAX    = {1'b0, {FRAC_BITS{1'b1}}};

  // Round-to-nearest offsets applied to the registered product.
  localparam logic [MUL_P_BITS-1:0] RND_GAIN  = MUL_P_BITS'(1) << (GAIN_FRAC - 1);
  localparam logic [MUL_P_BITS-1:0] RND_DRIVE = MUL_P_BITS'(1) << (DRIVE_FRAC - 1);
  localparam logic [MUL_P_BITS-1:0] RND_FRAC  = MUL_P_BITS'(1) << (FRAC_LO_BITS - 1);
  localparam logic [MUL_P_BITS-1:0] RND_SHAPE = MUL_P_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [MUL_P_BITS-1:0] RND_EXP   = MUL_P_BITS'(1) << (EXP_FRAC - 1);

  // Configuration registers.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_GAIN  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRIVE_GAIN  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_GAIN = 2'd2;
  localparam logic [GAIN_BITS-1:0] INPUT_GAIN_RST  = 16'd8192;
  localparam logic [GAIN_BITS-1:0] DRIVE_GAIN_RST  = 16'd1289;
  localparam logic [GAIN_BITS-1:0] OUTPUT_GAIN_RST = 16'd8192;

  // Microcode fields.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_IN_GAIN,
    MUL_DRIVE,
    MUL_FRAC,
    MUL_SHAPE,
    MUL_OUT_GAIN,
    MUL_EXP
  } mul_sel_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_GAIN,
    OP_ARG,
    OP_RD_A,
    OP_RD_B,
    OP_DIFF,
    OP_INTERP,
    OP_SHAPE,
    OP_EMIT,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_TAB_WRITE
  } uop_e;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_INPUT,
    WAIT_OUTPUT,
    WAIT_DIV
  } wait_e;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_ALWAYS,
    BR_TAB_MORE
  } branch_e;

  localparam int UPC_BITS = 5;
  typedef logic [UPC_BITS-1:0] upc_t;

  typedef struct packed {
    mul_sel_e mul;
    uop_e     op;
    wait_e    wait_on;
    branch_e  branch;
    upc_t     target;
  } uword_t;

  // Program addresses.
  localparam upc_t UP_DIV_LOAD  = 5'd0;
  localparam upc_t UP_DIV_STEP  = 5'd1;
  localparam upc_t UP_TAB_WRITE = 5'd2;
  localparam upc_t UP_IDLE      = 5'd3;
  localparam upc_t UP_MUL_IN    = 5'd4;
  localparam upc_t UP_GAIN      = 5'd5;
  localparam upc_t UP_MUL_DRIVE = 5'd6;
  localparam upc_t UP_ARG       = 5'd7;
  localparam upc_t UP_RD_A      = 5'd8;
  localparam upc_t UP_RD_B      = 5'd9;
  localparam upc_t UP_DIFF      = 5'd10;
  localparam upc_t UP_MUL_FRAC  = 5'd11;
  localparam upc_t UP_INTERP    = 5'd12;
  localparam upc_t UP_MUL_SHAPE = 5'd13;
  localparam upc_t UP_SHAPE     = 5'd14;
  localparam upc_t UP_MUL_OUT   = 5'd15;
  localparam upc_t UP_EMIT      = 5'd16;

  // Control store. The first three words build the tanh table after reset,
  // the rest process one sample.
  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    unique case (pc)
      UP_DIV_LOAD:  w = '{MUL_EXP,      OP_DIV_LOAD,  WAIT_NONE,   BR_NEXT,     UP_DIV_LOAD};
      UP_DIV_STEP:  w = '{MUL_NONE,     OP_DIV_STEP,  WAIT_DIV,    BR_NEXT,     UP_DIV_LOAD};
      UP_TAB_WRITE: w = '{MUL_NONE,     OP_TAB_WRITE, WAIT_NONE,   BR_TAB_MORE, UP_DIV_LOAD};
      UP_IDLE:      w = '{MUL_NONE,     OP_ACCEPT,    WAIT_INPUT,  BR_NEXT,     UP_IDLE};
      UP_MUL_IN:    w = '{MUL_IN_GAIN,  OP_NONE,      WAIT_NONE,   BR_NEXT,     UP_IDLE};
      UP_GAIN:      w = '{MUL_NONE,     OP_GAIN,      WAIT_NONE,   BR_NEXT,     UP_IDLE};
      UP_MUL_DRIVE: w = '{MUL_DRIVE,    OP_NONE,      WAIT_NONE,   BR_NEXT,     UP_IDLE};
      UP_ARG:       w = '{MUL_NONE,     OP_ARG,       WAIT_NONE,   BR_NEXT,     UP_IDLE};
      UP_RD_A:      w = '{MUL_NONE,     OP_RD_A,      WAIT_NONE,   BR_NEXT,     UP_IDLE};
      UP_RD_B:      w = '{MUL_NONE,     OP_RD_B,      WAIT_NONE,   BR_NEXT,     UP_IDLE};
      UP_DIFF:      w = '{MUL_NONE,     OP_DIFF,      WAIT_NONE,   BR_NEXT,     UP_IDLE};
      UP_MUL_FRAC:  w = '{MUL_FRAC,     OP_NONE,      WAIT_NONE,   BR_NEXT,     UP_IDLE};
      UP_INTERP:    w = '{MUL_NONE,     OP_INTERP,    WAIT_NONE,   BR_NEXT,     UP_IDLE};
      UP_MUL_SHAPE: w = '{MUL_SHAPE,    OP_NONE,      WAIT_NONE,   BR_NEXT,     UP_IDLE};
      UP_SHAPE:     w = '{MUL_NONE,     OP_SHAPE,     WAIT_NONE,   BR_NEXT,     UP_IDLE};
      UP_MUL_OUT:   w = '{MUL_OUT_GAIN, OP_NONE,      WAIT_NONE,   BR_NEXT,     UP_IDLE};
      UP_EMIT:      w = '{MUL_NONE,     OP_EMIT,      WAIT_OUTPUT, BR_ALWAYS,   UP_IDLE};
      default:      w = '{MUL_NONE,     OP_NONE,      WAIT_NONE,   BR_ALWAYS,   UP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/tanh_soft_clip_distortion.sv
`default_nettype none

// A taken sample is presented when the microprogram reaches its emit step.
// A new sample is taken only once the last is emitted; the 14-step microprogram runs
// every product through one shared multiplier and reads the table through one port.
// Reset clears control and running peaks and restores the gain defaults, then builds
// the 1025-entry tanh table with the bit-serial divider; inputs wait meanwhile.
// Configuration writes are taken at any time, including during the table build.
module tanh_soft_clip_distortion (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     cfg_we_i,
  input  wire logic [tscd_pkg::CFG_IDX_BITS-1:0]        cfg_idx_i,
  input  wire logic [tscd_pkg::GAIN_BITS-1:0]           cfg_data_i,
  input  wire logic                                     in_valid_i,
  output logic                                          in_ready_o,
  input  wire logic signed [tscd_pkg::SAMPLE_BITS-1:0]  sample_in_i,
  input  wire logic                                     block_end_i,
  output logic                                          out_valid_o,
  input  wire logic                                     out_ready_i,
  output logic signed [tscd_pkg::SAMPLE_BITS-1:0]       sample_out_o,
  output logic [tscd_pkg::G_BITS-1:0]                   peak_input_o,
  output logic [tscd_pkg::SAMPLE_BITS-1:0]              peak_output_o,
  output logic                                          peaks_valid_o
);

  localparam int SB = tscd_pkg::SAMPLE_BITS;
  localparam int GB = tscd_pkg::G_BITS;
  localparam int UB = tscd_pkg::U_BITS;
  localparam int TB = tscd_pkg::T_BITS;
  localparam int PB = tscd_pkg::MUL_P_BITS;
  localparam int AB = tscd_pkg::MUL_A_BITS;
  localparam int BB = tscd_pkg::MUL_B_BITS;
  localparam int IB = tscd_pkg::IDX_BITS;
  localparam int FL = tscd_pkg::FRAC_LO_BITS;
  localparam int EB = tscd_pkg::EXP_BITS;
  localparam int DB = tscd_pkg::DEN_BITS;
  localparam int QB = tscd_pkg::QUO_BITS;
  localparam int NB = tscd_pkg::NUM_BITS;
  localparam int CB = tscd_pkg::DIV_CNT_BITS;

  // Sequencer.
  tscd_pkg::upc_t   upc_q, upc_d;
  tscd_pkg::uword_t uw;
  logic             wait_now;
  logic             br_taken;

  // Configuration.
  logic [tscd_pkg::GAIN_BITS-1:0] in_gain_q, drive_gain_q, out_gain_q;

  // Sample datapath.
  logic [SB-1:0] raw_in;
  logic [SB-1:0] mag_d, mag_q;
  logic          end_q;
  logic [GB-1:0] g_q;
  logic [UB-1:0] u_q;
  logic [TB-1:0] a_q, diff_q, t_q;
  logic [GB-1:0] y_q;
  logic [AB-1:0] mul_a;
  logic [BB-1:0] mul_b;
  logic [PB-1:0] mul_p, prod_q;
  logic [PB-1:0] g_full, u_full, frac_full, y_full, o_full, e_full;
  logic [GB-1:0] g_d;
  logic [UB-1:0] u_d;
  logic [TB-1:0] t_d, diff_d;
  logic [SB-1:0] o_d;
  logic [IB-1:0] idx;
  logic [FL-1:0] ulow;
  logic          idx_top;
  logic          accept;
  logic          emit_go;

  // Peaks and output register.
  logic [GB-1:0] run_in_q, pin;
  logic [SB-1:0] run_out_q, pout;
  logic          out_valid_q;
  logic [SB-1:0] sample_out_q;
  logic [GB-1:0] peak_in_q;
  logic [SB-1:0] peak_out_q;
  logic          peaks_valid_q;

  // Table memory and its build state.
  logic [TB-1:0] tab_mem [tscd_pkg::TAB_ENTRIES];
  logic [TB-1:0] rdata_q;
  logic [IB-1:0] rd_addr;
  logic          rd_en;
  logic [IB-1:0] tab_addr_q;
  logic [EB-1:0] e_q, e_d;
  logic [DB-1:0] den_new, den_q;
  logic [NB-1:0] num_new;
  logic [DB-1:0] rem_q;
  logic [DB:0]   trial;
  logic          trial_ge;
  logic [QB-1:0] div_lo_q;
  logic [CB-1:0] div_cnt_q;

  // Decode the current control word and pick the next step.
  assign uw = tscd_pkg::ucode(upc_q);

  always_comb begin
    unique case (uw.wait_on)
      tscd_pkg::WAIT_INPUT:  wait_now = !in_valid_i;
      tscd_pkg::WAIT_OUTPUT: wait_now = out_valid_q && !out_ready_i;
      tscd_pkg::WAIT_DIV:    wait_now = (div_cnt_q != '0);
      default:               wait_now = 1'b0;
    endcase
    unique case (uw.branch)
      tscd_pkg::BR_ALWAYS:   br_taken = 1'b1;
      tscd_pkg::BR_TAB_MORE: br_taken = (tab_addr_q != IB'(tscd_pkg::TANH_DEPTH));
      default:               br_taken = 1'b0;
    endcase
    if (wait_now) begin
      upc_d = upc_q;
    end else if (br_taken) begin
      upc_d = uw.target;
    end else begin
      upc_d = upc_q + tscd_pkg::UPC_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= tscd_pkg::UP_DIV_LOAD;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign in_ready_o = (uw.op == tscd_pkg::OP_ACCEPT);
  assign accept     = in_valid_i && in_ready_o;
  assign emit_go    = (uw.op == tscd_pkg::OP_EMIT) && !(out_valid_q && !out_ready_i);

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_gain_q    <= tscd_pkg::INPUT_GAIN_RST;
      drive_gain_q <= tscd_pkg::DRIVE_GAIN_RST;
      out_gain_q   <= tscd_pkg::OUTPUT_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tscd_pkg::REG_INPUT_GAIN:  in_gain_q    <= cfg_data_i;
        tscd_pkg::REG_DRIVE_GAIN:  drive_gain_q <= cfg_data_i;
        tscd_pkg::REG_OUTPUT_GAIN: out_gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Magnitude of the incoming sample; the shaper is even in x.
  assign raw_in = sample_in_i;
  assign mag_d  = raw_in[SB-1] ? (SB'(0) - raw_in) : raw_in;

  // Table position from the drive argument.
  assign idx     = u_q[UB-1:FL];
  assign ulow    = u_q[FL-1:0];
  assign idx_top = (idx == IB'(tscd_pkg::TANH_DEPTH));

  // Shared multiplier operand selection.
  always_comb begin
    unique case (uw.mul)
      tscd_pkg::MUL_IN_GAIN: begin
        mul_a = AB'(mag_q);
        mul_b = BB'(in_gain_q);
      end
      tscd_pkg::MUL_DRIVE: begin
        mul_a = AB'(g_q);
        mul_b = BB'(drive_gain_q);
      end
      tscd_pkg::MUL_FRAC: begin
        mul_a = AB'(diff_q);
        mul_b = BB'(ulow);
      end
      tscd_pkg::MUL_SHAPE: begin
        mul_a = AB'(g_q);
        mul_b = BB'(t_q);
      end
      tscd_pkg::MUL_OUT_GAIN: begin
        mul_a = AB'(y_q);
        mul_b = BB'(out_gain_q);
      end
      tscd_pkg::MUL_EXP: begin
        mul_a = AB'(e_q);
        mul_b = tscd_pkg::EXP_RATIO_C;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PB'(mul_a) * PB'(mul_b);

  // Rounding and saturation of the registered product, one use per step.
  assign g_full    = (prod_q + tscd_pkg::RND_GAIN) >> tscd_pkg::GAIN_FRAC;
  assign u_full    = (prod_q + tscd_pkg::RND_DRIVE) >> tscd_pkg::DRIVE_FRAC;
  assign frac_full = (prod_q + tscd_pkg::RND_FRAC) >> FL;
  assign y_full    = (prod_q + tscd_pkg::RND_SHAPE) >> tscd_pkg::FRAC_BITS;
  assign o_full    = g_full;
  assign e_full    = (prod_q + tscd_pkg::RND_EXP) >> tscd_pkg::EXP_FRAC;

  assign g_d = (g_full > PB'(tscd_pkg::GAINED_MAX)) ? tscd_pkg::GAINED_MAX : GB'(g_full);
  assign u_d = (u_full > PB'(tscd_pkg::ARG_MAX)) ? tscd_pkg::ARG_MAX : UB'(u_full);
  assign o_d = (o_full > PB'(tscd_pkg::OUT_MAX)) ? tscd_pkg::OUT_MAX : SB'(o_full);
  assign e_d = (e_full > PB'(tscd_pkg::EXP_ONE_C)) ? tscd_pkg::EXP_ONE_C : EB'(e_full);
  assign t_d = a_q + TB'(frac_full);

  // Slope toward the next entry; the last entry has none.
  assign diff_d = (!idx_top && (rdata_q > a_q)) ? (rdata_q - a_q) : '0;

  // Peak updates including the current sample.
  assign pin  = (run_in_q > g_q) ? run_in_q : g_q;
  assign pout = (run_out_q > o_d) ? run_out_q : o_d;

  // Sample datapath registers.
  always_ff @(posedge clk_i) begin
    if (uw.mul != tscd_pkg::MUL_NONE) begin
      prod_q <= mul_p;
    end
    if (accept) begin
      mag_q <= mag_d;
      end_q <= block_end_i;
    end
    if (uw.op == tscd_pkg::OP_GAIN) begin
      g_q <= g_d;
    end
    if (uw.op == tscd_pkg::OP_ARG) begin
      u_q <= u_d;
    end
    if (uw.op == tscd_pkg::OP_RD_B) begin
      a_q <= rdata_q;
    end
    if (uw.op == tscd_pkg::OP_DIFF) begin
      diff_q <= diff_d;
    end
    if (uw.op == tscd_pkg::OP_INTERP) begin
      t_q <= t_d;
    end
    if (uw.op == tscd_pkg::OP_SHAPE) begin
      y_q <= GB'(y_full);
    end
  end

  // Output register and result payload.
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      sample_out_q <= o_d;
      if (end_q) begin
        peak_in_q     <= pin;
        peak_out_q    <= pout;
        peaks_valid_q <= 1'b1;
      end else begin
        peak_in_q     <= '0;
        peak_out_q    <= '0;
        peaks_valid_q <= 1'b0;
      end
    end
  end

  // Output valid and the running block peaks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      run_in_q    <= '0;
      run_out_q   <= '0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
        if (end_q) begin
          run_in_q  <= '0;
          run_out_q <= '0;
        end else begin
          run_in_q  <= pin;
          run_out_q <= pout;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = sample_out_q;
  assign peak_input_o  = peak_in_q;
  assign peak_output_o = peak_out_q;
  assign peaks_valid_o = peaks_valid_q;

  // Table memory: one write port for the build, one registered read port.
  assign rd_en   = (uw.op == tscd_pkg::OP_RD_A) || (uw.op == tscd_pkg::OP_RD_B);
  assign rd_addr = ((uw.op == tscd_pkg::OP_RD_B) && !idx_top) ? (idx + IB'(1)) : idx;

  always_ff @(posedge clk_i) begin
    if (uw.op == tscd_pkg::OP_TAB_WRITE) begin
      tab_mem[tab_addr_q] <= div_lo_q;
    end
    if (rd_en) begin
      rdata_q <= tab_mem[rd_addr];
    end
  end

  // Entry = round((1 - e) / (1 + e)) computed by restoring division, one bit a cycle.
  assign den_new = DB'(tscd_pkg::EXP_ONE_C) + DB'(e_q);
  assign num_new = (NB'(tscd_pkg::EXP_ONE_C - e_q) << tscd_pkg::FRAC_BITS)
                   + NB'(den_new >> 1);
  assign trial    = {rem_q, div_lo_q[QB-1]};
  assign trial_ge = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (uw.op == tscd_pkg::OP_DIV_LOAD) begin
      den_q    <= den_new;
      rem_q    <= DB'(num_new[NB-1:QB]);
      div_lo_q <= num_new[QB-1:0];
    end else if (uw.op == tscd_pkg::OP_DIV_STEP) begin
      rem_q    <= trial_ge ? DB'(trial - {1'b0, den_q}) : trial[DB-1:0];
      div_lo_q <= {div_lo_q[QB-2:0], trial_ge};
    end
  end

  // Build progress: entry address, exponential and bit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_addr_q <= '0;
      e_q        <= tscd_pkg::EXP_ONE_C;
      div_cnt_q  <= '0;
    end else begin
      if (uw.op == tscd_pkg::OP_DIV_LOAD) begin
        div_cnt_q <= CB'(QB - 1);
      end else if ((uw.op == tscd_pkg::OP_DIV_STEP) && (div_cnt_q != '0)) begin
        div_cnt_q <= div_cnt_q - CB'(1);
      end
      if (uw.op == tscd_pkg::OP_TAB_WRITE) begin
        tab_addr_q <= tab_addr_q + IB'(1);
        e_q        <= e_d;
      end
    end
  end

`ifndef SYNTHESIS
  // No sample is taken before the whole table has been written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (tab_addr_q == IB'(tscd_pkg::TAB_ENTRIES)))
    else $error("input taken while the tanh table is still being built");

  // A taken result empties the output register unless a new one loads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !emit_go) |=> !out_valid_o)
    else $error("result repeated after its transfer");

  // A pending result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !emit_go)
    else $error("pending result overwritten");

  // The shaper output is never negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !sample_out_o[SB-1])
    else $error("negative shaper output");

  // Table entries stay below one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == tscd_pkg::OP_TAB_WRITE) |-> !div_lo_q[QB-1])
    else $error("tanh table entry out of range");
`endif

endmodule

`default_nettype wire
